// ===== rtl/sts_pkg.sv =====
package sts_pkg;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int SINE_W   = 32;
    localparam int TERM_W   = 3;

    // Register reset and default series length
    localparam logic [TERM_W-1:0] TERM_COUNT_RESET = 3'd5;
    localparam int MAX_TERMS_DEFAULT = 5;

    // Datapath widths: magnitude, x^2 (Q.26), reciprocal, factor, term, accumulator
    localparam int MAG_W   = 16;
    localparam int X2_W    = 31;
    localparam int RECIP_W = 22;
    localparam int F_W     = 28;
    localparam int T_W     = 31;
    localparam int ACC_W   = 34;

    localparam int RECIP_SHIFT = 24;
    localparam int FRAC_BITS   = 26;
    localparam int ANGLE_FRAC  = 13;

    // round(2^24 / (2k*(2k+1))) for k = idx+1
    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            3'd0:    r = 22'd2796203;
            3'd1:    r = 22'd838861;
            3'd2:    r = 22'd399458;
            3'd3:    r = 22'd233017;
            3'd4:    r = 22'd152520;
            3'd5:    r = 22'd107546;
            3'd6:    r = 22'd79892;
            default: r = 22'd61681;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sine_taylor_series_unit.sv =====
// Channel     Direction  Handshake                       Payload
// s_axis      in         s_axis_tvalid / s_axis_tready   tdata[15:0] angle, tlast last_in
// m_axis      out        m_axis_tvalid / m_axis_tready   tdata[31:0] sine_value, tlast last_out
// cfg         in         cfg_valid / cfg_ready           cfg_data[2:0] term_count
//
// One angle enters per cycle while s_axis_tready is high, across MAX_TERMS + 4
// register stages: magnitude, x^2, factors, one multiplier stage per series term,
// then sign and saturation.
// Reset empties the pipeline and returns term_count to 5.
// Each stage holds its transfer only while the stage after it is full and stalled,
// so empty stages close up and input is still taken while a result waits.
// Configuration writes are always taken.
module sine_taylor_series_unit #(
    parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sts_pkg::ANGLE_W-1:0] s_axis_tdata,   // [15:0] angle
    input  logic                        s_axis_tlast,   // last_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sts_pkg::SINE_W-1:0]  m_axis_tdata,   // [31:0] sine_value
    output logic                        m_axis_tlast,   // last_out
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sts_pkg::TERM_W-1:0]  cfg_data        // [2:0] term_count
);

    localparam int NST   = MAX_TERMS + 4;
    localparam int N_W   = $clog2(MAX_TERMS + 1);
    localparam int MAG_W = sts_pkg::MAG_W;
    localparam int X2_W  = sts_pkg::X2_W;
    localparam int F_W   = sts_pkg::F_W;
    localparam int T_W   = sts_pkg::T_W;
    localparam int ACC_W = sts_pkg::ACC_W;
    localparam int FP_W  = X2_W + sts_pkg::RECIP_W;
    localparam int TP_W  = T_W + F_W;
    localparam int SINE_W = sts_pkg::SINE_W;

    // Control
    logic [sts_pkg::TERM_W-1:0] term_count_reg;
    logic [NST-1:0]             v_reg;
    logic [NST-1:0]             stage_en;

    // Sideband carried per stage
    logic           last_reg [0:NST-1];
    logic           sign_reg [0:NST-2];
    logic [N_W-1:0] n_reg    [0:NST-2];

    // Datapath
    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        mag_next;
    logic [X2_W-1:0]         x2_reg;
    logic [2*MAG_W-1:0]      x2_next;
    logic [T_W-1:0]          t_reg   [1:NST-2];
    logic signed [ACC_W-1:0] acc_reg [2:NST-2];
    logic [F_W-1:0]          f_reg   [2:NST-3][1:MAX_TERMS];
    logic [F_W-1:0]          f_next  [1:MAX_TERMS];
    logic [N_W-1:0]          n_next;
    logic [SINE_W-1:0]       sine_reg;
    logic [SINE_W-1:0]       sine_next;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= sts_pkg::TERM_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            term_count_reg <= cfg_data;
        end
    end

    // Stage enables: a stage advances when empty or when its successor advances
    always_comb
    begin
        stage_en[NST-1] = !v_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            stage_en[i] = !v_reg[i] || stage_en[i+1];
        end
    end

    assign s_axis_tready = stage_en[0];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (stage_en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: magnitude, sign and clamped term count
    always_comb
    begin
        mag_next = s_axis_tdata[sts_pkg::ANGLE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
        if (int'(term_count_reg) > MAX_TERMS)
        begin
            n_next = N_W'(MAX_TERMS);
        end
        else
        begin
            n_next = N_W'(term_count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            mag_reg <= mag_next;
        end
    end

    // Move sideband along with the data
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            sign_reg[0] <= s_axis_tdata[sts_pkg::ANGLE_W-1];
            last_reg[0] <= s_axis_tlast;
            n_reg[0]    <= n_next;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (stage_en[i])
            begin
                last_reg[i] <= last_reg[i-1];
            end
        end
        for (int i = 1; i < NST - 1; i++)
        begin
            if (stage_en[i])
            begin
                sign_reg[i] <= sign_reg[i-1];
                n_reg[i]    <= n_reg[i-1];
            end
        end
    end

    // Stage 1: x^2 and the leading term x in Q.26
    assign x2_next = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            x2_reg   <= x2_next[X2_W-1:0];
            t_reg[1] <= T_W'({mag_reg, {sts_pkg::ANGLE_FRAC{1'b0}}});
        end
    end

    // Stage 2: every factor x^2 / (2k(2k+1)) in parallel lanes
    always_comb
    begin
        logic [FP_W-1:0] prod;
        for (int k = 1; k <= MAX_TERMS; k++)
        begin
            prod = FP_W'(x2_reg) * FP_W'(sts_pkg::recip_of(3'(k - 1)))
                 + (FP_W'(1) << (sts_pkg::RECIP_SHIFT - 1));
            f_next[k] = prod[sts_pkg::RECIP_SHIFT +: F_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            t_reg[2]   <= t_reg[1];
            acc_reg[2] <= signed'(ACC_W'(t_reg[1]));
            for (int k = 1; k <= MAX_TERMS; k++)
            begin
                f_reg[2][k] <= f_next[k];
            end
        end
    end

    // Term stages: next term by one multiply, previous term into the sum
    for (genvar j = 1; j <= MAX_TERMS; j++)
    begin : g_term
        localparam int S = 2 + j;

        logic [TP_W-1:0]         tprod;
        logic [T_W-1:0]          t_next;
        logic signed [ACC_W-1:0] acc_next;

        always_comb
        begin
            tprod  = TP_W'(t_reg[S-1]) * TP_W'(f_reg[S-1][j])
                   + (TP_W'(1) << (sts_pkg::FRAC_BITS - 1));
            t_next = tprod[sts_pkg::FRAC_BITS +: T_W];
            acc_next = acc_reg[S-1];
            if ((j >= 2) && (int'(n_reg[S-1]) >= j - 1))
            begin
                if (((j - 1) % 2) == 1)
                begin
                    acc_next = acc_reg[S-1] - signed'(ACC_W'(t_reg[S-1]));
                end
                else
                begin
                    acc_next = acc_reg[S-1] + signed'(ACC_W'(t_reg[S-1]));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[S])
            begin
                t_reg[S]   <= t_next;
                acc_reg[S] <= acc_next;
            end
        end

        // Hand the remaining factors on
        if (S <= NST - 3)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (stage_en[S])
                begin
                    for (int k = 1; k <= MAX_TERMS; k++)
                    begin
                        f_reg[S][k] <= f_reg[S-1][k];
                    end
                end
            end
        end
    end

    // Final stage: last term, sign of the angle, saturation
    always_comb
    begin
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] res;
        sum = acc_reg[NST-2];
        if (int'(n_reg[NST-2]) >= MAX_TERMS)
        begin
            if ((MAX_TERMS % 2) == 1)
            begin
                sum = acc_reg[NST-2] - signed'(ACC_W'(t_reg[NST-2]));
            end
            else
            begin
                sum = acc_reg[NST-2] + signed'(ACC_W'(t_reg[NST-2]));
            end
        end
        res = sign_reg[NST-2] ? -sum : sum;
        if (res > signed'(ACC_W'({1'b0, {(SINE_W-1){1'b1}}})))
        begin
            sine_next = {1'b0, {(SINE_W-1){1'b1}}};
        end
        else if (res < -signed'(ACC_W'({1'b1, {(SINE_W-1){1'b0}}})))
        begin
            sine_next = {1'b1, {(SINE_W-1){1'b0}}};
        end
        else
        begin
            sine_next = res[SINE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[NST-1])
        begin
            sine_reg <= sine_next;
        end
    end

    assign m_axis_tvalid = v_reg[NST-1];
    assign m_axis_tdata  = sine_reg;
    assign m_axis_tlast  = last_reg[NST-1];

    // An empty output stage never blocks the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NST-1] |-> s_axis_tready)
        else $error("input stalled with output stage empty");

    // An accepted transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted angle lost at first stage");

    // Series terms stay below 2^30 for every angle
    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-2] |-> (t_reg[NST-2][T_W-1] == 1'b0))
        else $error("series term overflowed its range");

    // The series never reaches the saturation limits for a Q3.13 angle
    a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata != {1'b0, {(SINE_W-1){1'b1}}}) &&
                           (m_axis_tdata != {1'b1, {(SINE_W-1){1'b0}}})))
        else $error("result hit saturation");

endmodule

// ===== bench/sine_taylor_series_unit_test.sv =====
`timescale 1ns / 1ps

module sine_taylor_series_unit_test;

    localparam int SERIES_MAX   = sts_pkg::MAX_TERMS_DEFAULT;
    localparam int PIPE_DEPTH   = SERIES_MAX + 4;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 88;
    localparam int PROBE_COUNT  = 25;

    // One directed probe: term count to run with, the angle, batch end, and a
    // hand-worked sine where one is obvious
    typedef struct packed {
        logic [sts_pkg::TERM_W-1:0]  terms;
        logic [sts_pkg::ANGLE_W-1:0] angle;
        logic                        lst;
        logic                        known;
        logic [sts_pkg::SINE_W-1:0]  want;
    } probe_t;

    typedef struct {
        logic [sts_pkg::SINE_W-1:0] sine;
        logic                       lst;
    } sine_result_t;

    localparam probe_t PROBES [0:PROBE_COUNT-1] = '{
        '{3'd5, 16'h0000, 1'b0, 1'b1, 32'h0000_0000},
        '{3'd5, 16'h7FFF, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'h8000, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'h0001, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'hFFFF, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'h3244, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'hCDBC, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'h6488, 1'b1, 1'b0, 32'h0},
        '{3'd5, 16'h5555, 1'b0, 1'b0, 32'h0},
        '{3'd5, 16'hAAAA, 1'b0, 1'b0, 32'h0},
        '{3'd0, 16'h7FFF, 1'b0, 1'b1, 32'h0FFF_E000},
        '{3'd0, 16'h8000, 1'b0, 1'b1, 32'hF000_0000},
        '{3'd0, 16'h0001, 1'b0, 1'b1, 32'h0000_2000},
        '{3'd0, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_E000},
        '{3'd0, 16'h0000, 1'b0, 1'b1, 32'h0000_0000},
        '{3'd7, 16'h7FFF, 1'b0, 1'b0, 32'h0},
        '{3'd7, 16'h8000, 1'b0, 1'b0, 32'h0},
        '{3'd6, 16'h4000, 1'b1, 1'b0, 32'h0},
        '{3'd1, 16'h7FFF, 1'b0, 1'b0, 32'h0},
        '{3'd1, 16'h8000, 1'b0, 1'b0, 32'h0},
        '{3'd2, 16'hC000, 1'b0, 1'b0, 32'h0},
        '{3'd3, 16'h6488, 1'b0, 1'b0, 32'h0},
        '{3'd4, 16'h9B78, 1'b0, 1'b0, 32'h0},
        '{3'd4, 16'h0000, 1'b0, 1'b1, 32'h0000_0000},
        '{3'd5, 16'h2000, 1'b1, 1'b0, 32'h0}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [sts_pkg::ANGLE_W-1:0] s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [sts_pkg::SINE_W-1:0]  m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [sts_pkg::TERM_W-1:0]  cfg_data;

    sine_result_t                sine_q [$];
    logic [sts_pkg::TERM_W-1:0]  terms_cfg;
    logic                        cur_known;
    logic [sts_pkg::SINE_W-1:0]  cur_want;
    bit                          calm;
    int                          error_count;
    int                          idle_cycles;
    int                          ready_hold;

    sine_taylor_series_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Truncated Taylor sine in Q6.26: x, then alternating terms each built from
    // the previous one times x^2 / (2k(2k+1)), rounded half up on the magnitude
    function automatic logic [sts_pkg::SINE_W-1:0] taylor_sine(
        input logic [sts_pkg::ANGLE_W-1:0] angle,
        input logic [sts_pkg::TERM_W-1:0]  terms
    );
        logic [63:0] mag;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] factor;
        logic [63:0] recip;
        logic [63:0] denom;
        longint      acc;
        int          n;
        mag  = angle[sts_pkg::ANGLE_W-1] ? (64'h1_0000 - {48'd0, angle}) : {48'd0, angle};
        n    = (terms > SERIES_MAX) ? SERIES_MAX : int'(terms);
        x_sq = mag * mag;
        term = mag << 13;
        acc  = longint'(term);
        for (int k = 1; k <= n; k++)
        begin
            denom  = 64'(2 * k) * 64'(2 * k + 1);
            recip  = (64'd1 << 24) + denom / 2;
            recip  = recip / denom;
            factor = (x_sq * recip + (64'd1 << 23)) >> 24;
            term   = (term * factor + (64'd1 << 25)) >> 26;
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (angle[sts_pkg::ANGLE_W-1])
            acc = -acc;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[sts_pkg::SINE_W-1:0];
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        error_count++;
    endtask

    // Watch every transfer at the rising edge: queue predictions, check results,
    // track the register and count cycles with nothing moving
    always @(posedge clk)
    begin
        sine_result_t want;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                want.sine = cur_known ? cur_want : taylor_sine(s_axis_tdata, terms_cfg);
                want.lst  = s_axis_tlast;
                sine_q.push_back(want);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (sine_q.size() == 0)
                    report_error($sformatf("result %h with nothing expected", m_axis_tdata));
                else
                begin
                    want = sine_q.pop_front();
                    if (m_axis_tdata !== want.sine)
                        report_error($sformatf("sine_value got %h want %h",
                                               m_axis_tdata, want.sine));
                    if (m_axis_tlast !== want.lst)
                        report_error($sformatf("last_out got %b want %b",
                                               m_axis_tlast, want.lst));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                terms_cfg = cfg_data;
                moved     = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
        else
        begin
            // Track the register reset and hold the idle count at zero
            terms_cfg   = sts_pkg::TERM_COUNT_RESET;
            idle_cycles = 0;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Result side back-pressure: random stall bursts, none once the run calms
    initial
    begin
        m_axis_tready = 1'b0;
        ready_hold    = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                ready_hold--;
                m_axis_tready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                ready_hold    = $urandom_range(1, 18) - 1;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_angle(
        input logic [sts_pkg::ANGLE_W-1:0] angle,
        input logic                        lst,
        input logic                        known,
        input logic [sts_pkg::SINE_W-1:0]  want
    );
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = angle;
        s_axis_tlast  = lst;
        cur_known     = known;
        cur_want      = want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold input back until every outstanding result has come out
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sine_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_terms(input logic [sts_pkg::TERM_W-1:0] terms);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = terms;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly uniform angles, with the range ends and the smallest steps mixed in
    function automatic logic [sts_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'h0001;
            4:       return 16'hFFFF;
            default: return sts_pkg::ANGLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [sts_pkg::TERM_W-1:0] phase_terms [0:PHASE_COUNT-1];
        phase_terms   = '{3'd0, 3'd5, 3'd7, 3'd1, 3'd3, 3'd6, 3'd2, 3'd4};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cur_known     = 1'b0;
        cur_want      = '0;
        calm          = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed probes, switching term count only when the row asks for it
        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            if (PROBES[i].terms != terms_cfg)
                write_terms(PROBES[i].terms);
            send_angle(PROBES[i].angle, PROBES[i].lst, PROBES[i].known, PROBES[i].want);
        end

        // Random phases, one term count each; the final phase runs without idling
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_terms(phase_terms[p]);
            if (p == PHASE_COUNT - 1)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 40 && !calm)
                    drain_results();
                send_angle(pick_angle(), $urandom_range(0, 7) == 0, 1'b0, '0);
            end
        end

        drain_results();
        repeat (2 * PIPE_DEPTH) @(negedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
